### rtl/core/cca_pkg.sv
package cca_pkg;

  // Table geometry
  localparam int MAX_CLUSTERS = 1024;
  localparam int IDX_W        = $clog2(MAX_CLUSTERS);
  localparam int LIVE_W       = $clog2(MAX_CLUSTERS + 1);
  // Wide enough for cluster numbers up to MAX_CLUSTERS + 2
  localparam int SCAN_W       = $clog2(MAX_CLUSTERS + 3);

  // Field widths
  localparam int OP_W    = 2;
  localparam int CLUS_W  = 28;
  localparam int LINK_W  = 28;
  localparam int STAT_W  = 2;
  localparam int GRANT_W = 11;
  localparam int HINT_W  = 11;
  localparam int COUNT_W = 11;

  // Command queue depth, a power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Link markers and reset values
  localparam logic [LINK_W-1:0]  END_OF_CHAIN = 28'hFFFFFFF;
  localparam logic [LINK_W-1:0]  BAD_MARK     = 28'hFFFFFF7;
  localparam logic [COUNT_W-1:0] COUNT_RESET  = 11'd1024;
  localparam logic [HINT_W-1:0]  HINT_RESET   = 11'd2;

  // Classified command word passed from front to back
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              ok;
    logic [IDX_W-1:0]  idx;
    logic [LINK_W-1:0] link_value;
  } cmd_t;

  // Back-end status seen by the front
  typedef struct packed {
    logic clear_done;
  } back_stat_t;

endpackage

### rtl/core/cca_front.sv
module cca_front import cca_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   op,
  input  logic [CLUS_W-1:0] cluster,
  input  logic [LINK_W-1:0] link_value,
  input  logic [LIVE_W-1:0] live_n,
  input  back_stat_t        stat,
  input  logic              q_ready,
  output logic              q_push,
  output cmd_t              q_data
);

  logic [CLUS_W-1:0] limit;
  logic              in_range;
  logic              blocked;

  // Hold off input until the table clearing pass is over
  always_ff @(posedge clk) begin
    if (rst) begin
      blocked <= 1'b1;
    end else begin
      blocked <= !stat.clear_done;
    end
  end

  // Valid clusters are 2 up to live count + 1
  assign limit    = CLUS_W'(live_n) + CLUS_W'(2);
  assign in_range = (cluster >= CLUS_W'(2)) && (cluster < limit);

  assign in_ready = q_ready && !blocked && stat.clear_done;
  assign q_push   = in_valid && in_ready;

  // Classify the word: range flag and table index
  always_comb begin
    q_data.op         = op;
    q_data.ok         = in_range;
    q_data.idx        = IDX_W'(cluster - CLUS_W'(2));
    q_data.link_value = link_value;
  end

endmodule

### rtl/core/cca_queue.sv
module cca_queue import cca_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic not_full,
  output logic not_empty,
  input  logic pop,
  output cmd_t pop_data
);

  cmd_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;

  assign not_full  = (fill != Q_CNT_W'(Q_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = entry[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - Q_CNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/cca_back.sv
module cca_back import cca_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [LIVE_W-1:0]  live_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  cmd_t               q_data,
  output back_stat_t         stat,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [STAT_W-1:0]  res_status,
  output logic [GRANT_W-1:0] res_grant,
  output logic [LINK_W-1:0]  res_link
);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_EXEC     = 3'd2;
  localparam logic [2:0] ST_RD_WAIT  = 3'd3;
  localparam logic [2:0] ST_SCAN_RD  = 3'd4;
  localparam logic [2:0] ST_SCAN_CHK = 3'd5;
  localparam logic [2:0] ST_WALK_RD  = 3'd6;
  localparam logic [2:0] ST_WALK_CHK = 3'd7;

  logic [LINK_W-1:0] link_mem [MAX_CLUSTERS];
  logic [LINK_W-1:0] rdata;

  logic [2:0]        state, state_next;
  cmd_t              cmd, cmd_next;
  logic [SCAN_W-1:0] scan_pos, scan_pos_next;
  logic [IDX_W-1:0]  walk_idx, walk_idx_next;
  logic [LIVE_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0]  clear_addr, clear_addr_next;
  logic [HINT_W-1:0] hint, hint_next;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;

  logic               fin;
  logic [STAT_W-1:0]  fin_status;
  logic [GRANT_W-1:0] fin_grant;
  logic [LINK_W-1:0]  fin_link;

  logic [SCAN_W-1:0] scan_limit;
  logic [SCAN_W-1:0] scan_start;
  logic [SCAN_W-1:0] scan_wrap;
  logic [IDX_W-1:0]  scan_idx;
  logic [LIVE_W-1:0] cnt_inc;
  logic              next_ok;

  assign stat.clear_done = (state != ST_CLEAR);

  // Scan helpers: start point from the hint, wrap to cluster 2 past the end
  always_comb begin
    scan_limit = SCAN_W'(live_n) + SCAN_W'(2);
    if ((hint < HINT_W'(2)) || (32'(hint) >= 32'(live_n) + 32'd2)) begin
      scan_start = SCAN_W'(2);
    end else begin
      scan_start = SCAN_W'(hint);
    end
    scan_wrap = scan_pos + SCAN_W'(1);
    if (scan_wrap >= scan_limit) begin
      scan_wrap = SCAN_W'(2);
    end
    scan_idx = IDX_W'(scan_pos - SCAN_W'(2));
    cnt_inc  = cnt + LIVE_W'(1);
    // A link below the end markers and within the live range continues the chain
    next_ok  = (rdata >= LINK_W'(2)) && (rdata < LINK_W'(live_n) + LINK_W'(2));
  end

  // Sequence table operations
  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    scan_pos_next   = scan_pos;
    walk_idx_next   = walk_idx;
    cnt_next        = cnt;
    clear_addr_next = clear_addr;
    hint_next       = hint;
    mem_we          = 1'b0;
    mem_waddr       = cmd.idx;
    mem_wdata       = '0;
    mem_raddr       = cmd.idx;
    q_pop           = 1'b0;
    fin             = 1'b0;
    fin_status      = STAT_OK;
    fin_grant       = '0;
    fin_link        = '0;

    unique case (state)
      ST_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = clear_addr;
        clear_addr_next = clear_addr + IDX_W'(1);
        if (clear_addr == IDX_W'(MAX_CLUSTERS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid && !res_valid) begin
          q_pop      = 1'b1;
          cmd_next   = q_data;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd.op)
          OP_READ: begin
            if (cmd.ok) begin
              state_next = ST_RD_WAIT;
            end else begin
              fin        = 1'b1;
              fin_status = STAT_RANGE;
              fin_link   = BAD_MARK;
            end
          end
          OP_WRITE: begin
            fin = 1'b1;
            if (cmd.ok) begin
              mem_we    = 1'b1;
              mem_wdata = cmd.link_value;
            end else begin
              fin_status = STAT_RANGE;
            end
          end
          OP_ALLOC: begin
            if (live_n == '0) begin
              fin        = 1'b1;
              fin_status = STAT_FULL;
            end else begin
              scan_pos_next = scan_start;
              cnt_next      = '0;
              state_next    = ST_SCAN_RD;
            end
          end
          OP_FREE: begin
            if (cmd.ok) begin
              walk_idx_next = cmd.idx;
              cnt_next      = '0;
              state_next    = ST_WALK_RD;
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_RD_WAIT: begin
        fin      = 1'b1;
        fin_link = rdata;
      end
      ST_SCAN_RD: begin
        mem_raddr  = scan_idx;
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (rdata == '0) begin
          // Mark the free entry end of chain and grant it
          mem_we    = 1'b1;
          mem_waddr = scan_idx;
          mem_wdata = END_OF_CHAIN;
          hint_next = HINT_W'(scan_pos + SCAN_W'(1));
          fin       = 1'b1;
          fin_grant = GRANT_W'(scan_pos);
        end else if (cnt_inc == live_n) begin
          fin        = 1'b1;
          fin_status = STAT_FULL;
        end else begin
          cnt_next      = cnt_inc;
          scan_pos_next = scan_wrap;
          state_next    = ST_SCAN_RD;
        end
      end
      ST_WALK_RD: begin
        mem_raddr  = walk_idx;
        state_next = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        // Drop this link and follow the old one
        mem_we    = 1'b1;
        mem_waddr = walk_idx;
        if ((cnt_inc == live_n) || !next_ok) begin
          fin = 1'b1;
        end else begin
          walk_idx_next = IDX_W'(rdata - LINK_W'(2));
          cnt_next      = cnt_inc;
          state_next    = ST_WALK_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_next = ST_IDLE;
    end
  end

  // Link table: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= link_mem[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      hint       <= HINT_RESET;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clear_addr <= clear_addr_next;
      hint       <= hint_next;
      if (fin) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Working registers and result word
  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    scan_pos <= scan_pos_next;
    walk_idx <= walk_idx_next;
    cnt      <= cnt_next;
    if (fin) begin
      res_status <= fin_status;
      res_grant  <= fin_grant;
      res_link   <= fin_link;
    end
  end

endmodule

### rtl/core/cluster_chain_allocator.sv
// Cluster chain allocator: a 1024-entry table of 28-bit cluster links with a
// next-free hint. An accepted word goes straight into the command queue, and
// the back end pops it into its execute state; a read adds one registered
// table access, while a write, an out-of-range word or a free of an invalid
// start answers from the execute state. Allocate probes table entries from
// the hint, and free zeroes chain links one by one; both are paced by the
// link table, which serves one read and one write per cycle and needs a read
// and a check for each entry. The back end takes no new word while a result
// waits on the output. After reset the table is cleared one entry per cycle,
// and in_ready stays low until the clearing pass is over; cluster_count
// writes are taken at any time. A new word is accepted into the two-entry
// command queue, if it has room, while a result waits on the output.
module cluster_chain_allocator import cca_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    op,
  input  logic [CLUS_W-1:0]  cluster,
  input  logic [LINK_W-1:0]  link_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  status,
  output logic [GRANT_W-1:0] alloc_cluster,
  output logic [LINK_W-1:0]  link_out,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data
);

  logic [COUNT_W-1:0] cluster_count;
  logic [LIVE_W-1:0]  live_n;
  back_stat_t         stat;
  logic               q_ready;
  logic               q_push;
  cmd_t               q_push_data;
  logic               q_valid;
  logic               q_pop;
  cmd_t               q_pop_data;

  // Hold the cluster count register
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= COUNT_RESET;
    end else if (cfg_wr_en) begin
      cluster_count <= cfg_wr_data;
    end
  end

  // Clamp the count to the table size
  always_comb begin
    if (32'(cluster_count) > MAX_CLUSTERS) begin
      live_n = LIVE_W'(MAX_CLUSTERS);
    end else begin
      live_n = LIVE_W'(cluster_count);
    end
  end

  cca_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .cluster    (cluster),
    .link_value (link_value),
    .live_n     (live_n),
    .stat       (stat),
    .q_ready    (q_ready),
    .q_push     (q_push),
    .q_data     (q_push_data)
  );

  cca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .not_full  (q_ready),
    .not_empty (q_valid),
    .pop       (q_pop),
    .pop_data  (q_pop_data)
  );

  cca_back u_back (
    .clk        (clk),
    .rst        (rst),
    .live_n     (live_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_pop_data),
    .stat       (stat),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res_status (status),
    .res_grant  (alloc_cluster),
    .res_link   (link_out)
  );

  // A full answer never grants a cluster
  a_full_no_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_FULL) |-> (alloc_cluster == '0))
    else $error("full status with a granted cluster");

  // A granted cluster comes with ok status and no link
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (alloc_cluster != '0) |-> (status == STAT_OK) && (link_out == '0))
    else $error("grant with bad status or link");

  // Out of range answers carry either no link or the bad marker
  a_range_link: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_RANGE) |->
      (alloc_cluster == '0) && ((link_out == '0) || (link_out == BAD_MARK)))
    else $error("range error with unexpected payload");

  // No word enters while the table is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    !stat.clear_done |-> !q_push)
    else $error("word accepted during clearing pass");

endmodule
